// ===== rtl/core/mfrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfrp_pkg
// Shared constants, command codes and controller/datapath interface types
// for the motion frame record and playback unit.
// ----------------------------------------------------------------------------
package mfrp_pkg;

	// default sizing of the frame store
	localparam int MAX_FRAMES_DEF = 1024;
	localparam int CHANNELS_DEF   = 8;

	// fixed field widths
	localparam int FUNC_W     = 3;
	localparam int ANGLES_W   = 64;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int FRAMES_W   = 11;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd50;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_START_REC  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_STOP_REC   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_START_PLAY = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_STOP_PLAY  = 3'd4;

	// controller to datapath strobes
	typedef struct packed {
		logic accept;      // register the incoming command
		logic exec;        // apply the command to the state
		logic rd_en;       // read the frame store
		logic rd_next;     // read address is play position plus one
		logic chk0;        // test first read frame
		logic chk1;        // test second read frame
		logic fin;         // end of sequence handling
		logic load;        // load a result into the output register
		logic load_second; // the loaded result is the second applied frame
	} mfrp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic       tick_play; // registered command is a tick during playback
		logic       hit;       // read frame is due
		logic [1:0] hits;      // frames applied so far for this command
		logic       out_free;  // output register can take a result
	} mfrp_stat_t;

endpackage

// ===== rtl/core/mfrp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfrp_ctrl
// Controller state machine: sequences command execution, frame store reads,
// end of sequence handling and result transfers.
// ----------------------------------------------------------------------------
module mfrp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mfrp_pkg::mfrp_stat_t stat,
	output mfrp_pkg::mfrp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_CHK0 = 3'd2;
	localparam logic [2:0] ST_CHK1 = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_OUT0 = 3'd5;
	localparam logic [2:0] ST_OUT1 = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.tick_play) begin
					cmd.rd_en = 1'b1;
					state_nxt = ST_CHK0;
				end else begin
					state_nxt = ST_OUT0;
				end
			end
			ST_CHK0: begin
				cmd.chk0 = 1'b1;
				if (stat.hit) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_nxt   = ST_CHK1;
				end else begin
					state_nxt = ST_FIN;
				end
			end
			ST_CHK1: begin
				cmd.chk1  = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin   = 1'b1;
				state_nxt = ST_OUT0;
			end
			ST_OUT0: begin
				if (stat.out_free) begin
					cmd.load  = 1'b1;
					state_nxt = (stat.hits == 2'd2) ? ST_OUT1 : ST_IDLE;
				end
			end
			ST_OUT1: begin
				if (stat.out_free) begin
					cmd.load        = 1'b1;
					cmd.load_second = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/core/mfrp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfrp_dp
// Datapath: configuration register, recorder and player state, frame store
// memory, applied frame holding registers and the output register.
// ----------------------------------------------------------------------------
module mfrp_dp #(
	parameter int MAX_FRAMES = mfrp_pkg::MAX_FRAMES_DEF,
	parameter int CHANNELS   = mfrp_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mfrp_pkg::INTERVAL_W-1:0]     cfg_wdata,
	input  logic [mfrp_pkg::FUNC_W-1:0]         func,
	input  logic [mfrp_pkg::ANGLES_W-1:0]       angles_in,
	input  logic                                loop_enable,
	input  mfrp_pkg::mfrp_cmd_t                 cmd,
	output mfrp_pkg::mfrp_stat_t                stat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mfrp_pkg::ANGLES_W-1:0]       angles_out,
	output logic                                apply,
	output logic                                recording_now,
	output logic                                playing_now,
	output logic [mfrp_pkg::FRAMES_W-1:0]       frames_stored,
	output logic                                last
);

	localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
	localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int ANG_W  = 8 * CHANNELS;
	localparam int TIME_W = mfrp_pkg::TIME_W;
	localparam int MEM_W  = TIME_W + ANG_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_FRAMES);

	// configuration and command registers
	logic [mfrp_pkg::INTERVAL_W-1:0] interval_q;
	logic [mfrp_pkg::FUNC_W-1:0]     func_q;
	logic [ANG_W-1:0]                angles_q;
	logic                            loop_q;

	// recorder and player state
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  pos_q;
	logic              rec_q;
	logic              play_q;
	logic              looping_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] rec_origin_q;
	logic [TIME_W-1:0] last_cap_q;
	logic [TIME_W-1:0] play_origin_q;
	logic [1:0]        hits_q;

	// applied frames and store read data
	logic [ANG_W-1:0] hold0_q;
	logic [ANG_W-1:0] hold1_q;
	logic [MEM_W-1:0] rd_data_q;
	logic [MEM_W-1:0] frame_mem [MAX_FRAMES];

	// output register
	logic                            out_valid_q;
	logic [mfrp_pkg::ANGLES_W-1:0]   out_angles_q;
	logic                            out_apply_q;
	logic                            out_rec_q;
	logic                            out_play_q;
	logic [mfrp_pkg::FRAMES_W-1:0]   out_frames_q;
	logic                            out_last_q;

	logic [TIME_W-1:0] now_inc;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] rd_time;
	logic [ANG_W-1:0]  rd_angles;
	logic [CNT_W-1:0]  pos_inc;
	logic              is_tick;
	logic              is_start_rec;
	logic              cap_due;
	logic              store_full;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [TIME_W-1:0] wr_time;
	logic [ADDR_W-1:0] rd_addr;
	logic              hit;

	// capture and playback decode
	always_comb begin
		now_inc      = now_q + 1'b1;
		elapsed      = now_q - play_origin_q;
		rd_time      = rd_data_q[MEM_W-1:ANG_W];
		rd_angles    = rd_data_q[ANG_W-1:0];
		pos_inc      = pos_q + 1'b1;
		is_tick      = (func_q == mfrp_pkg::FUNC_TICK);
		is_start_rec = (func_q == mfrp_pkg::FUNC_START_REC);
		store_full   = (total_q >= FULL_CNT);
		cap_due      = is_tick && rec_q &&
		               ((now_inc - last_cap_q) >= TIME_W'(interval_q));
		wr_en        = cmd.exec && (is_start_rec || (cap_due && !store_full));
		wr_addr      = is_start_rec ? '0 : ADDR_W'(total_q);
		wr_time      = is_start_rec ? '0 : (now_inc - rec_origin_q);
		rd_addr      = cmd.rd_next ? ADDR_W'(pos_inc) : ADDR_W'(pos_q);
		hit          = (pos_q < total_q) && (rd_time <= elapsed);
	end

	// status to controller
	always_comb begin
		stat.tick_play = is_tick && play_q && (total_q != '0);
		stat.hit       = hit;
		stat.hits      = hits_q;
		stat.out_free  = !out_valid_q || out_ready;
	end

	// frame store, write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= {wr_time, angles_q};
		end
		if (cmd.rd_en) begin
			rd_data_q <= frame_mem[rd_addr];
		end
	end

	// command and applied frame payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q   <= func;
			angles_q <= angles_in[ANG_W-1:0];
			loop_q   <= loop_enable;
		end
		if (cmd.chk0 && hit) begin
			hold0_q <= rd_angles;
		end
		if (cmd.chk1 && hit) begin
			hold1_q <= rd_angles;
		end
	end

	// recorder and player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q    <= mfrp_pkg::INTERVAL_RESET;
			total_q       <= '0;
			pos_q         <= '0;
			rec_q         <= 1'b0;
			play_q        <= 1'b0;
			looping_q     <= 1'b0;
			now_q         <= '0;
			rec_origin_q  <= '0;
			last_cap_q    <= '0;
			play_origin_q <= '0;
			hits_q        <= '0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				hits_q <= '0;
			end
			if (cmd.exec) begin
				case (func_q)
					mfrp_pkg::FUNC_TICK: begin
						now_q <= now_inc;
						if (cap_due) begin
							last_cap_q <= now_inc;
							if (store_full) begin
								rec_q <= 1'b0;
							end else begin
								total_q <= total_q + 1'b1;
							end
						end
					end
					mfrp_pkg::FUNC_START_REC: begin
						play_q       <= 1'b0;
						rec_q        <= 1'b1;
						rec_origin_q <= now_q;
						last_cap_q   <= now_q;
						total_q      <= CNT_W'(1);
					end
					mfrp_pkg::FUNC_STOP_REC: begin
						rec_q <= 1'b0;
					end
					mfrp_pkg::FUNC_START_PLAY: begin
						if (total_q != '0) begin
							rec_q         <= 1'b0;
							play_q        <= 1'b1;
							looping_q     <= loop_q;
							pos_q         <= '0;
							play_origin_q <= now_q;
						end
					end
					mfrp_pkg::FUNC_STOP_PLAY: begin
						play_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			// due frame consumed
			if ((cmd.chk0 || cmd.chk1) && hit) begin
				pos_q  <= pos_inc;
				hits_q <= hits_q + 1'b1;
			end
			// end of sequence: loop or stop
			if (cmd.fin && (pos_q >= total_q)) begin
				if (looping_q) begin
					pos_q         <= '0;
					play_origin_q <= now_q;
				end else begin
					play_q <= 1'b0;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, status taken after the command completes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (cmd.load_second) begin
				out_angles_q <= mfrp_pkg::ANGLES_W'(hold1_q);
			end else if (hits_q != '0) begin
				out_angles_q <= mfrp_pkg::ANGLES_W'(hold0_q);
			end else begin
				out_angles_q <= '0;
			end
			out_apply_q  <= cmd.load_second || (hits_q != '0);
			out_last_q   <= cmd.load_second || (hits_q != 2'd2);
			out_rec_q    <= rec_q;
			out_play_q   <= play_q;
			out_frames_q <= mfrp_pkg::FRAMES_W'(total_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign angles_out    = out_angles_q;
	assign apply         = out_apply_q;
	assign recording_now = out_rec_q;
	assign playing_now   = out_play_q;
	assign frames_stored = out_frames_q;
	assign last          = out_last_q;

endmodule

// ===== rtl/core/motion_frame_record_playback_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_frame_record_playback_unit
// Records timed frames of packed channel angles and plays them back, driven
// by one command per input transfer (tick, start/stop record, start/stop
// playback). Controller and datapath with a simple dual-port frame store.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+----------------------
//  config   | cfg_we, cfg_wdata                         | cfg_we high
//  command  | in_valid, in_ready, func, angles_in,      | in_valid && in_ready
//           | loop_enable                               |
//  result   | out_valid, out_ready, angles_out, apply,  | out_valid && out_ready
//           | recording_now, playing_now,               |
//           | frames_stored, last                       |
//
// A command runs from transfer through the execute state to the result load
// when no playback read is needed; a playback tick adds the first check and
// end of sequence states, the second check when a frame is due, and a second
// load for two; the one read port and one-step-per-state control set this.
// A new command is taken once the previous one has loaded its last result;
// a result stalled in the output register holds up only the next load.
// Reset is immediate; the frame store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module motion_frame_record_playback_unit #(
	parameter int MAX_FRAMES = mfrp_pkg::MAX_FRAMES_DEF,
	parameter int CHANNELS   = mfrp_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mfrp_pkg::INTERVAL_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mfrp_pkg::FUNC_W-1:0]     func,
	input  logic [mfrp_pkg::ANGLES_W-1:0]   angles_in,
	input  logic                            loop_enable,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mfrp_pkg::ANGLES_W-1:0]   angles_out,
	output logic                            apply,
	output logic                            recording_now,
	output logic                            playing_now,
	output logic [mfrp_pkg::FRAMES_W-1:0]   frames_stored,
	output logic                            last
);

	mfrp_pkg::mfrp_cmd_t  cmd;
	mfrp_pkg::mfrp_stat_t stat;

	// sequencing
	mfrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// state, store and result register
	mfrp_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.CHANNELS   (CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.func          (func),
		.angles_in     (angles_in),
		.loop_enable   (loop_enable),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.angles_out    (angles_out),
		.apply         (apply),
		.recording_now (recording_now),
		.playing_now   (playing_now),
		.frames_stored (frames_stored),
		.last          (last)
	);

`ifndef SYNTHESIS
	// a result that is not the last one always carries a frame
	a_first_of_two_applies: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> apply)
		else $error("non-final result without an applied frame");

	// recording and playback exclude each other
	a_rec_play_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(recording_now && playing_now))
		else $error("recording and playback both active");

	// a result is only loaded into a free output register
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> stat.out_free)
		else $error("result loaded over a pending result");

	// one command in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while another is in flight");
`endif

endmodule
